>>> sv/tlapc_pkg.sv
// Shared types, constants and elaboration-time helpers for the posture cost block.
// Used by the top level and the checker; depends on nothing.
package tlapc_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 24;
   localparam int ZW         = 40;   // angle word before reduction
   localparam int XW         = 34;   // rotation datapath, Q2.30 plus headroom
   localparam int NUMB_TERM  = 56;   // numerator exponent of the two radial terms

   localparam logic signed [ZW-1:0] PI_Q30      = 40'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 40'sd1686629713;
   localparam logic signed [ZW-1:0] TWO_PI_Q30  = 40'sd6746518852;
   localparam logic [31:0]          ONE_Q30     = 32'd1073741824;
   localparam logic [31:0]          COST_MAX    = 32'hFFFF_FFFF;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LINK1_LENGTH = 4'd0,
      CSR_LINK2_LENGTH = 4'd1,
      CSR_SING_EPS     = 4'd2,
      CSR_WS_EPS       = 4'd3,
      CSR_J1_LOWER     = 4'd4,
      CSR_J1_UPPER     = 4'd5,
      CSR_J2_LOWER     = 4'd6,
      CSR_J2_UPPER     = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] joint1_angle;
      logic signed [15:0] joint2_angle;
   } req_type;

   typedef struct packed {
      logic [31:0] posture_cost;
      logic        cost_saturated;
   } rsp_type;

   // Joint angles and the quadrant fold flag, carried beside the datapath
   typedef struct packed {
      logic [15:0] q1;
      logic [15:0] q2;
      logic        flip;
   } side_type;

   // Squared rotation gain in Q30, each product step truncated
   function automatic logic [63:0] cordic_k2(input int n);
      logic [63:0] k2;
      begin
         k2 = 64'(ONE_Q30);
         for (int i = 0; i < 32; i++) begin
            if (i < n) begin
               k2 = k2 + (k2 >> (2 * i));
            end
         end
         return k2;
      end
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] b_v;
      begin
         res = '0;
         rem = v;
         for (int k = 31; k >= 0; k--) begin
            b_v = 64'd1 << (2 * k);
            if (rem >= res + b_v) begin
               rem = rem - (res + b_v);
               res = (res >> 1) + b_v;
            end else begin
               res = res >> 1;
            end
         end
         return res;
      end
   endfunction

endpackage

>>> sv/two_link_arm_posture_cost.sv
// Posture cost of a planar two-link arm: singularity, joint-limit and workspace terms.
// Throughput: one item per cycle while the skid is empty; the depth is set by the
// rotation stages, the 29-stage root, then the 32-stage reciprocal units side by side.
// A skid stage at the output keeps req_ready high while one result waits.
// Synchronous reset empties the pipeline and loads the register defaults.
module two_link_arm_posture_cost
   import tlapc_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS   = 13,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int N      = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
   localparam int SH     = 30 - ANGLE_FRAC_BITS;
   localparam int WRAPS  = (ANGLE_FRAC_BITS >= 15) ? 1 :
                           ((32'd1 << (15 - ANGLE_FRAC_BITS)) / 6 + 1);
   localparam logic [63:0] K2  = cordic_k2(N);
   localparam logic [63:0] KQ  = isqrt64(K2 << 30);
   localparam logic [63:0] RCP = (64'd1 << 62) / KQ;
   localparam int RW     = 58;
   localparam int SQ     = RW / 2;
   localparam int NUMB_J = 16 + 2 * ANGLE_FRAC_BITS;
   localparam int T      = N + 9 + SQ;
   localparam int LAST   = T + 34;
   localparam int SIDE_N = N + 6 + SQ;

   // ---------------- configuration ----------------
   logic [15:0] link1_ff, link2_ff;
   logic [23:0] sing_eps_ff, ws_eps_ff;
   logic [15:0] j1_lo_ff, j1_hi_ff, j2_lo_ff, j2_hi_ff;
   logic [31:0] l12_ff, l1sq_ff, l2sq_ff;
   logic [28:0] rmin_ff, rmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link1_ff    <= 16'd4096;
         link2_ff    <= 16'd4096;
         sing_eps_ff <= 24'd16777;
         ws_eps_ff   <= 24'd16777;
         j1_lo_ff    <= 16'h9B78;
         j1_hi_ff    <= 16'd25736;
         j2_lo_ff    <= 16'h9B78;
         j2_hi_ff    <= 16'd25736;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_LINK1_LENGTH: link1_ff    <= csr_wdata[15:0];
            CSR_LINK2_LENGTH: link2_ff    <= csr_wdata[15:0];
            CSR_SING_EPS:     sing_eps_ff <= csr_wdata;
            CSR_WS_EPS:       ws_eps_ff   <= csr_wdata;
            CSR_J1_LOWER:     j1_lo_ff    <= csr_wdata[15:0];
            CSR_J1_UPPER:     j1_hi_ff    <= csr_wdata[15:0];
            CSR_J2_LOWER:     j2_lo_ff    <= csr_wdata[15:0];
            CSR_J2_UPPER:     j2_hi_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Products, difference and sum of the link lengths, refreshed every cycle
   always_ff @(posedge clock) begin
      l12_ff  <= link1_ff * link2_ff;
      l1sq_ff <= link1_ff * link1_ff;
      l2sq_ff <= link2_ff * link2_ff;
      rmin_ff <= (link1_ff > link2_ff) ? {1'b0, link1_ff - link2_ff, 12'b0}
                                       : {1'b0, link2_ff - link1_ff, 12'b0};
      rmax_ff <= {17'(link1_ff) + 17'(link2_ff), 12'b0};
   end

   // ---------------- flow control ----------------
   logic       adv;
   logic [LAST:0] v_ff;
   logic       rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in, p_data;

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAST-1:0], req_valid};
      end
   end

   // ---------------- input and angle reduction ----------------
   req_type            in_ff;
   side_type           side_ff [1:SIDE_N];
   logic signed [XW-1:0] z1_ff;
   logic signed [ZW-1:0] zr;
   logic               flip_v;

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;
      end
   end

   always_comb begin
      zr = {{(ZW-16){in_ff.joint2_angle[15]}}, in_ff.joint2_angle} <<< SH;
      for (int j = 0; j < WRAPS; j++) begin
         if (zr > PI_Q30) begin
            zr = zr - TWO_PI_Q30;
         end else if (zr < -PI_Q30) begin
            zr = zr + TWO_PI_Q30;
         end
      end
      flip_v = 1'b0;
      if (zr > HALF_PI_Q30) begin
         zr     = zr - PI_Q30;
         flip_v = 1'b1;
      end else if (zr < -HALF_PI_Q30) begin
         zr     = zr + PI_Q30;
         flip_v = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z1_ff      <= zr[XW-1:0];
         side_ff[1] <= '{q1: in_ff.joint1_angle, q2: in_ff.joint2_angle, flip: flip_v};
         for (int k = 2; k <= SIDE_N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------- rotation stages ----------------
   logic signed [XW-1:0] cx_ff [N];
   logic signed [XW-1:0] cy_ff [N];
   logic signed [XW-1:0] cz_ff [N];

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cordic
         logic signed [XW-1:0] xi, yi, zi, xs, ys, at;
         if (gi == 0) begin : g_first
            assign xi = $signed({2'b00, ONE_Q30});
            assign yi = '0;
            assign zi = z1_ff;
         end else begin : g_rest
            assign xi = cx_ff[gi-1];
            assign yi = cy_ff[gi-1];
            assign zi = cz_ff[gi-1];
         end
         assign xs = xi >>> gi;
         assign ys = yi >>> gi;
         assign at = $signed({2'b00, ATAN_Q30[gi]});

         always_ff @(posedge clock) begin
            if (adv) begin
               if (zi >= 0) begin
                  cx_ff[gi] <= xi - ys;
                  cy_ff[gi] <= yi + xs;
                  cz_ff[gi] <= zi - at;
               end else begin
                  cx_ff[gi] <= xi + ys;
                  cy_ff[gi] <= yi - xs;
                  cz_ff[gi] <= zi + at;
               end
            end
         end
      end
   endgenerate

   // ---------------- gain removal: multiply by reciprocal, then correct ----------------
   logic [31:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff;
   logic        xneg1_ff, xneg2_ff;
   logic [63:0] mx1_ff, my1_ff, px2_ff, py2_ff;
   logic [31:0] qx2_ff, qy2_ff;
   logic signed [XW-1:0] xf, yf, xabs, yabs;

   assign xf   = cx_ff[N-1];
   assign yf   = cy_ff[N-1];
   assign xabs = (xf < 0) ? -xf : xf;
   assign yabs = (yf < 0) ? -yf : yf;

   always_ff @(posedge clock) begin
      if (adv) begin
         ax1_ff   <= xabs[31:0];
         ay1_ff   <= yabs[31:0];
         xneg1_ff <= xf[XW-1];
         mx1_ff   <= xabs[31:0] * RCP[31:0];
         my1_ff   <= yabs[31:0] * RCP[31:0];
         ax2_ff   <= ax1_ff;
         ay2_ff   <= ay1_ff;
         xneg2_ff <= xneg1_ff;
         qx2_ff   <= mx1_ff[63:32];
         qy2_ff   <= my1_ff[63:32];
         px2_ff   <= mx1_ff[63:32] * KQ[31:0];
         py2_ff   <= my1_ff[63:32] * KQ[31:0];
      end
   end

   logic [63:0] remx, remy;
   logic [31:0] qx, qy, cmag;
   logic signed [31:0] cs3_ff;
   logic [30:0] as3_ff;

   always_comb begin
      remx = {2'b00, ax2_ff, 30'b0} - px2_ff;
      remy = {2'b00, ay2_ff, 30'b0} - py2_ff;
      qx   = qx2_ff + 32'(remx >= KQ);
      qy   = qy2_ff + 32'(remy >= KQ);
      cmag = (qx > ONE_Q30) ? ONE_Q30 : qx;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // sign of cos follows the rotated x and the quadrant fold
         cs3_ff <= (xneg2_ff ^ side_ff[N+3].flip) ? -$signed(cmag) : $signed(cmag);
         as3_ff <= (qy > ONE_Q30) ? ONE_Q30[30:0] : qy[30:0];
      end
   end

   // ---------------- manipulability and reach radius ----------------
   logic [62:0]        wprod;
   logic signed [64:0] cprod;
   logic [31:0]        w4_ff;
   logic signed [34:0] cross4_ff;
   logic [63:0]        ww5_ff;
   logic [33:0]        r25_ff;
   logic signed [36:0] r2t;
   logic [56:0]        dens6_ff;
   logic [56:0]        ds_ff [0:SQ+1];

   assign wprod = l12_ff * as3_ff;
   assign cprod = $signed({1'b0, l12_ff}) * cs3_ff;
   assign r2t   = $signed({5'b0, l1sq_ff}) + $signed({5'b0, l2sq_ff})
                + $signed({cross4_ff[34], cross4_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (adv) begin
         w4_ff     <= wprod[61:30];
         cross4_ff <= cprod[64:30];
         ww5_ff    <= w4_ff * w4_ff;
         r25_ff    <= (r2t < 0) ? '0 : r2t[33:0];
         dens6_ff  <= {1'b0, ww5_ff[63:8]} + {17'b0, sing_eps_ff, 16'b0};
         ds_ff[0]  <= dens6_ff;
         for (int k = 1; k <= SQ + 1; k++) begin
            ds_ff[k] <= ds_ff[k-1];
         end
      end
   end

   logic [SQ-1:0] root_v;

   tlapc_sqrt #(.RW(RW)) u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand ({r25_ff, 24'b0}),
      .root     (root_v)
   );

   // ---------------- workspace margin and joint distances ----------------
   logic signed [30:0] d_a, d_b, d7_ff;
   logic signed [16:0] ja7_ff [4];
   logic [57:0]        dd8_ff;
   logic [31:0]        jsq8_ff [4];
   logic [50:0]        denw9_ff;
   logic [31:0]        denj9_ff [4];
   logic signed [33:0] jprod [4];
   logic signed [61:0] dprod;
   side_type           sd;

   assign sd  = side_ff[SIDE_N];
   assign d_a = $signed({2'b0, root_v}) - $signed({2'b0, rmin_ff});
   assign d_b = $signed({2'b0, rmax_ff}) - $signed({2'b0, root_v});
   assign dprod = d7_ff * d7_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         jprod[j] = ja7_ff[j] * ja7_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d7_ff     <= (d_a < d_b) ? d_a : d_b;
         ja7_ff[0] <= $signed({sd.q1[15], sd.q1}) - $signed({j1_lo_ff[15], j1_lo_ff});
         ja7_ff[1] <= $signed({j1_hi_ff[15], j1_hi_ff}) - $signed({sd.q1[15], sd.q1});
         ja7_ff[2] <= $signed({sd.q2[15], sd.q2}) - $signed({j2_lo_ff[15], j2_lo_ff});
         ja7_ff[3] <= $signed({j2_hi_ff[15], j2_hi_ff}) - $signed({sd.q2[15], sd.q2});
         dd8_ff    <= dprod[57:0];
         denw9_ff  <= {1'b0, dd8_ff[57:8]} + {11'b0, ws_eps_ff, 16'b0};
         for (int j = 0; j < 4; j++) begin
            jsq8_ff[j]  <= jprod[j][31:0];
            denj9_ff[j] <= jsq8_ff[j];
         end
      end
   end

   // ---------------- reciprocals ----------------
   logic [31:0] tq_s, tq_w;
   logic        ts_s, ts_w;
   logic [31:0] tq_j [4];
   logic        ts_j [4];

   tlapc_div #(.DW(57), .NUMB(NUMB_TERM)) u_div_sing (
      .clock (clock), .en (adv), .den (ds_ff[SQ+1]), .quo (tq_s), .sat (ts_s)
   );

   tlapc_div #(.DW(51), .NUMB(NUMB_TERM)) u_div_ws (
      .clock (clock), .en (adv), .den (denw9_ff), .quo (tq_w), .sat (ts_w)
   );

   generate
      for (gi = 0; gi < 4; gi++) begin : g_joint
         tlapc_div #(.DW(32), .NUMB(NUMB_J)) u_div_joint (
            .clock (clock), .en (adv), .den (denj9_ff[gi]), .quo (tq_j[gi]), .sat (ts_j[gi])
         );
      end
   endgenerate

   // ---------------- sum and saturate ----------------
   logic [33:0] sa_ff, sb_ff;
   logic        sat1_ff;
   logic [34:0] sum_v;
   rsp_type     out_ff;

   assign sum_v = 35'(sa_ff) + 35'(sb_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff   <= 34'(tq_s) + 34'(tq_w) + 34'(tq_j[0]);
         sb_ff   <= 34'(tq_j[1]) + 34'(tq_j[2]) + 34'(tq_j[3]);
         sat1_ff <= ts_s | ts_w | ts_j[0] | ts_j[1] | ts_j[2] | ts_j[3];
         if (sum_v > 35'(COST_MAX)) begin
            out_ff.posture_cost   <= COST_MAX;
            out_ff.cost_saturated <= 1'b1;
         end else begin
            out_ff.posture_cost   <= sum_v[31:0];
            out_ff.cost_saturated <= sat1_ff;
         end
      end
   end

   assign p_data = out_ff;

   // ---------------- output register and skid ----------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (v_ff[LAST]) begin
         // park the transfer in the skid when the output is still held
         if (rsp_valid_in) begin
            skid_valid_in = 1'b1;
            skid_data_in  = p_data;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = p_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/tlapc_sqrt.sv
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on nothing; the pipeline advances only while en is high.
module tlapc_sqrt #(
   parameter int RW = 58
) (
   input  logic                clock,
   input  logic                en,
   input  logic [RW-1:0]       radicand,
   output logic [RW/2-1:0]     root
);
   localparam int H = RW / 2;

   logic [RW-1:0] rad_ff  [H];
   logic [H:0]    rem_ff  [H];
   logic [H-1:0]  root_ff [H];

   genvar k;
   generate
      for (k = 0; k < H; k++) begin : g_stage
         logic [RW-1:0] rad_i;
         logic [H:0]    rem_i;
         logic [H-1:0]  root_i;
         logic [H+2:0]  t_v;
         logic [H+2:0]  trial_v;

         if (k == 0) begin : g_first
            assign rad_i  = radicand;
            assign rem_i  = '0;
            assign root_i = '0;
         end else begin : g_rest
            assign rad_i  = rad_ff[k-1];
            assign rem_i  = rem_ff[k-1];
            assign root_i = root_ff[k-1];
         end

         assign t_v     = {rem_i, rad_i[RW-1 -: 2]};
         assign trial_v = {1'b0, root_i, 2'b01};

         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[k] <= {rad_i[RW-3:0], 2'b00};
               if (t_v >= trial_v) begin
                  rem_ff[k]  <= (H+1)'(t_v - trial_v);
                  root_ff[k] <= {root_i[H-2:0], 1'b1};
               end else begin
                  rem_ff[k]  <= t_v[H:0];
                  root_ff[k] <= {root_i[H-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign root = root_ff[H-1];

endmodule

>>> sv/tlapc_div.sv
// Pipelined reciprocal 2^NUMB / den with a 32-bit saturating quotient.
// One quotient bit per stage, 32 stages; depends on nothing.
module tlapc_div #(
   parameter int DW   = 57,
   parameter int NUMB = 56
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] den,
   output logic [31:0]   quo,
   output logic          sat
);
   // Part of the numerator above the quotient bits
   localparam logic [DW:0] R0 = {{DW{1'b0}}, 1'b1} << (NUMB - 32);

   logic [DW:0]   r_ff [32];
   logic [31:0]   q_ff [32];
   logic [DW-1:0] d_ff [32];
   logic          s_ff [32];

   genvar k;
   generate
      for (k = 0; k < 32; k++) begin : g_stage
         logic [DW:0]   r_i;
         logic [31:0]   q_i;
         logic [DW-1:0] d_i;
         logic          s_i;
         logic [DW:0]   t_v;

         if (k == 0) begin : g_first
            assign r_i = R0;
            assign q_i = '0;
            assign d_i = den;
            // Zero divisor and quotients past 32 bits both land here
            assign s_i = ({1'b0, den} <= R0);
         end else begin : g_rest
            assign r_i = r_ff[k-1];
            assign q_i = q_ff[k-1];
            assign d_i = d_ff[k-1];
            assign s_i = s_ff[k-1];
         end

         assign t_v = {r_i[DW-1:0], 1'b0};

         always_ff @(posedge clock) begin
            if (en) begin
               d_ff[k] <= d_i;
               s_ff[k] <= s_i;
               if (t_v >= {1'b0, d_i}) begin
                  r_ff[k] <= t_v - {1'b0, d_i};
                  q_ff[k] <= {q_i[30:0], 1'b1};
               end else begin
                  r_ff[k] <= t_v;
                  q_ff[k] <= {q_i[30:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   assign sat = s_ff[31];
   assign quo = s_ff[31] ? 32'hFFFF_FFFF : q_ff[31];

endmodule

>>> sv/tlapc_checker.sv
// Port-level checks for the posture cost block, bound to the top level.
// Depends on tlapc_pkg for the payload types.
module tlapc_checker
   import tlapc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data,
   input logic                  csr_we,
   input logic [CSR_ADDR_W-1:0] csr_addr,
   input logic [CSR_DATA_W-1:0] csr_wdata
);
   logic [7:0] pend_ff;

   // Items taken but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transfer dropped or changed while stalled");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("result with no item outstanding");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cost_saturated |-> rsp_data.posture_cost == COST_MAX)
      else $error("saturated cost below full scale");

   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && $past(rsp_valid && !rsp_ready))
      else $error("input held without a stalled result");

endmodule

bind two_link_arm_posture_cost tlapc_checker u_checker (.*);
